// ----- rtl/bda_pkg.sv -----
// bda_pkg: shared types, constants and the multiples-of-ten table for the
// binary to decimal ascii converter. No dependencies.
package bda_pkg;

  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned MAG_W           = VALUE_W - 1;
  localparam int unsigned CHAR_W          = 6;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned DIGIT_COUNT_DEF = 10;
  localparam int unsigned DIGIT_COUNT_MAX = 19;
  localparam int unsigned POS_EXT_W       = $clog2(DIGIT_COUNT_MAX);

  // only 10^0 .. 10^9 can give a nonzero digit for a 31-bit magnitude
  localparam int unsigned TBL_ROWS  = 10;
  localparam int unsigned TBL_IDX_W = $clog2(TBL_ROWS);
  localparam int unsigned MULT_W    = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [MAG_W-1:0] mag;
  } item_t;

  typedef logic [9:0][MULT_W-1:0] mult_row_t;
  typedef mult_row_t [TBL_ROWS-1:0] mult_tbl_t;

  // row p, column k holds k * 10^p
  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t         tbl;
    logic [MULT_W-1:0] pw;
    pw = MULT_W'(1);
    for (int p = 0; p < TBL_ROWS; p++) begin
      for (int k = 0; k < 10; k++) begin
        tbl[p][k] = MULT_W'(MULT_W'(k) * pw);
      end
      pw = MULT_W'(pw * MULT_W'(10));
    end
    return tbl;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult_tbl();

endpackage

// ----- rtl/bda_front.sv -----
// bda_front: accepts input values, folds negatives to zero and holds them
// in a two-entry queue for the digit sequencer. Depends on bda_pkg.
module bda_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [bda_pkg::VALUE_W-1:0] value_i,
  output logic                           item_valid_o,
  input  logic                           item_ready_i,
  output bda_pkg::item_t                 item_o
);
  import bda_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  item_t             cls_item;
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  // negative values print as a single zero
  always_comb begin
    cls_item.mag = value_i[VALUE_W-1] ? '0 : value_i[MAG_W-1:0];
  end

  assign in_ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + QCNT_W'(1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - QCNT_W'(1))
    else $error("queue count missed a pop");
`endif

endmodule

// ----- rtl/bda_back.sv -----
// bda_back: digit sequencer, one power of ten per cycle from the top down
// unless output stalls, with a registered character output. Depends on bda_pkg.
module bda_back #(
  parameter int unsigned DIGIT_COUNT = bda_pkg::DIGIT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  bda_pkg::item_t              item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bda_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_char_o
);
  import bda_pkg::*;

  localparam int unsigned POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [POS_W-1:0] TOP_POS = POS_W'(DIGIT_COUNT - 1);

  logic                 busy_q, busy_d;
  logic                 started_q, started_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [MAG_W-1:0]     rem_q, rem_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;

  logic [POS_EXT_W-1:0] pos_ext;
  logic                 in_tbl;
  mult_row_t            row;
  logic [9:1]           ge;
  logic [DIGIT_W-1:0]   digit;
  logic [MAG_W-1:0]     sub;
  logic                 last_pos, emit, out_free, step, take;

  always_comb begin
    pos_ext = POS_EXT_W'(pos_q);
    in_tbl  = (pos_ext < POS_EXT_W'(TBL_ROWS));
    row     = MULT_TBL[in_tbl ? pos_ext[TBL_IDX_W-1:0] : '0];
    for (int k = 1; k < 10; k++) begin
      ge[k] = in_tbl && (MULT_W'(rem_q) >= row[k]);
    end
    // multiples rise with k, so the highest hit is the digit (saturates at 9)
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (ge[k]) begin
        digit = DIGIT_W'(k);
      end
    end
    sub = row[digit][MAG_W-1:0];
  end

  assign last_pos     = (pos_q == '0);
  // units digit always goes out, which also covers a zero value
  assign emit         = busy_q && ((digit != '0) || started_q || last_pos);
  assign out_free     = !out_valid_q || out_ready_i;
  assign step         = busy_q && (!emit || out_free);
  assign item_ready_o = !busy_q || (step && last_pos);
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    busy_d    = busy_q;
    started_d = started_q;
    pos_d     = pos_q;
    rem_d     = rem_q;
    if (take) begin
      busy_d    = 1'b1;
      started_d = 1'b0;
      pos_d     = TOP_POS;
      rem_d     = item_i.mag;
    end else if (step && last_pos) begin
      busy_d = 1'b0;
    end else if (step) begin
      started_d = started_q || emit;
      pos_d     = pos_q - POS_W'(1);
      rem_d     = rem_q - sub;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
      char_d      = ASCII_ZERO + CHAR_W'(digit);
      last_d      = last_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      started_q   <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      started_q   <= started_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_char_o  = last_q;

`ifndef SYNTHESIS
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (char_q >= ASCII_ZERO) && (char_q <= ASCII_NINE))
    else $error("character outside 0..9");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q <= TOP_POS)
    else $error("digit position beyond top");

  a_units_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_pos |=> out_valid_q && last_q)
    else $error("units digit did not close the number");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit && !last_pos |=> out_valid_q && !last_q)
    else $error("last flag on a non-final character");
`endif

endmodule

// ----- rtl/binary_to_decimal_ascii.sv -----
// binary_to_decimal_ascii: top level of the binary to decimal ascii
// converter. Depends on bda_pkg, bda_front and bda_back.
//
// Converts a signed 32-bit value into its decimal ASCII characters, most
// significant first, one character per output transaction, leading zeros
// dropped and last_char_o set on the final character; zero and every
// negative value give the single character '0'. Values enter a two-entry
// queue and a digit sequencer works one power of ten per cycle while the
// output is not stalled, visiting every position (positions that only carry
// leading zeros included); the next value is loaded in the cycle its
// predecessor's units digit leaves.
module binary_to_decimal_ascii #(
  parameter int unsigned DIGIT_COUNT = bda_pkg::DIGIT_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [bda_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bda_pkg::CHAR_W-1:0]         digit_char_o,
  output logic                               last_char_o
);
  import bda_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_ready;

  bda_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  bda_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
